FILE: rtl/sgr_pkg.sv
// Shared types, constants and glyph table for the scaled glyph square generator.
`default_nettype none

package sgr_pkg;

    localparam int GLYPH_COUNT = 13;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_POS   = GLYPH_COLS * GLYPH_ROWS;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(GLYPH_ROWS);

    localparam logic [7:0] GLYPH_ADVANCE = 8'd6;

    localparam logic [GLYPH_IDX_W-1:0] BLANK_GLYPH = GLYPH_IDX_W'(10);
    localparam logic [GLYPH_IDX_W-1:0] DOT_GLYPH   = GLYPH_IDX_W'(11);
    localparam logic [GLYPH_IDX_W-1:0] VEE_GLYPH   = GLYPH_IDX_W'(12);

    localparam logic [7:0] CODE_ZERO = 8'h30;
    localparam logic [7:0] CODE_NINE = 8'h39;
    localparam logic [7:0] CODE_DOT  = 8'h2E;
    localparam logic [7:0] CODE_VEE  = 8'h56;

    // Configuration register indexes
    localparam logic CFG_GLYPH_SCALE = 1'b0;
    localparam logic CFG_FILL_COLOR  = 1'b1;

    localparam logic [4:0]  SCALE_RESET = 5'd1;
    localparam logic [15:0] COLOR_RESET = 16'hFFFF;

    // Column bitmaps, row r is bit r of each column byte
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h77, 8'h08, 8'h08, 8'h08, 8'h77}
    };

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic glyph_blank;
        logic scan_last;
        logic out_free;
        logic bits_live;
    } t_sts;

    function automatic logic [GLYPH_IDX_W-1:0] glyph_select(input logic [7:0] code);
        logic [GLYPH_IDX_W-1:0] idx;
        idx = BLANK_GLYPH;
        if (code inside {[CODE_ZERO:CODE_NINE]}) begin
            idx = GLYPH_IDX_W'(code - CODE_ZERO);
        end else if (code == CODE_DOT) begin
            idx = DOT_GLYPH;
        end else if (code == CODE_VEE) begin
            idx = VEE_GLYPH;
        end
        return idx;
    endfunction

    // Flatten a glyph column-major: position col*ROWS+row
    function automatic logic [GLYPH_POS-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
        logic [GLYPH_POS-1:0] bits;
        bits = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            bits[c*GLYPH_ROWS +: GLYPH_ROWS] = GLYPH_ROM[idx][c][GLYPH_ROWS-1:0];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scaled_glyph_rect_generator.sv
// Top level of the scaled 5x7 glyph square generator.
//
//  channel   direction  handshake                  words
//  in        input      i_in_valid / o_in_ready    char_code, start_text, start_x, start_y
//  out       output     o_out_valid / i_out_ready  rect_x, rect_y, rect_color, last_rect
//  cfg       input      i_cfg_wr_en, no wait       glyph_scale, fill_color
//
// A character is accepted, then its glyph positions are scanned column-major up to its
// last lit dot; a blank glyph is only accepted and moves the cursor, with no scan.
// The pace is set by the single-position glyph scan; only lit dots load a square word.
// A held output word stalls the scan; input is taken again once the last word is loaded.
// Reset is synchronous: scale 1, color white, cursor and line at zero.
`default_nettype none

module scaled_glyph_rect_generator
    import sgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_start_text,
    input  wire logic [7:0]  i_start_x,
    input  wire logic [7:0]  i_start_y,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_rect_x,
    output logic [7:0]       o_rect_y,
    output logic [15:0]      o_rect_color,
    output logic             o_last_rect
);

    t_cmd cmd;
    t_sts sts;

    sgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char_code  (i_char_code),
        .i_start_text (i_start_text),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_rect_color (o_rect_color),
        .o_last_rect  (o_last_rect)
    );

endmodule

`default_nettype wire

FILE: rtl/sgr_ctrl.sv
// Control state machine: accepts characters and paces the glyph scan.
`default_nettype none

module sgr_ctrl
    import sgr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // blank glyphs only move the cursor, no scan
                if (i_in_valid && !i_sts.glyph_blank) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.out_free && i_sts.scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.step = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_scan_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> i_sts.bits_live)
        else $error("scan running with no glyph bits left");

    a_scan_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.out_free && i_sts.scan_last) |=> o_in_ready)
        else $error("controller did not return to idle after last position");

endmodule

`default_nettype wire

FILE: rtl/sgr_dp.sv
// Datapath: config registers, cursor, glyph shift register and output word.
`default_nettype none

module sgr_dp
    import sgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_start_text,
    input  wire logic [7:0]  i_start_x,
    input  wire logic [7:0]  i_start_y,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_rect_x,
    output logic [7:0]       o_rect_y,
    output logic [15:0]      o_rect_color,
    output logic             o_last_rect
);

    logic [4:0]           r_glyph_scale;
    logic [15:0]          r_fill_color;
    logic [7:0]           r_cursor_x;
    logic [7:0]           r_line_y;
    logic [7:0]           r_base_x;
    logic [GLYPH_POS-1:0] r_bits;
    logic [ROW_W-1:0]     r_row;
    logic [7:0]           r_xoff;
    logic [7:0]           r_yoff;
    logic                 r_out_valid;
    logic [7:0]           r_rect_x;
    logic [7:0]           r_rect_y;
    logic [15:0]          r_rect_color;
    logic                 r_last_rect;

    logic [7:0] n_base_x;
    logic [7:0] n_line_y;
    logic [7:0] advance;
    logic [7:0] scale_w;
    logic       at_last;

    assign scale_w  = {3'b000, r_glyph_scale};
    assign advance  = scale_w * GLYPH_ADVANCE;
    assign n_base_x = i_start_text ? i_start_x : r_cursor_x;
    assign n_line_y = i_start_text ? i_start_y : r_line_y;
    assign at_last  = (r_bits[GLYPH_POS-1:1] == '0);

    always_comb begin
        o_sts.glyph_blank = (glyph_select(i_char_code) == BLANK_GLYPH);
        o_sts.scan_last   = at_last;
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.bits_live   = |r_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_scale <= SCALE_RESET;
            r_fill_color  <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_GLYPH_SCALE: r_glyph_scale <= i_cfg_wdata[4:0];
                CFG_FILL_COLOR:  r_fill_color  <= i_cfg_wdata;
                default:         r_fill_color  <= r_fill_color;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_line_y   <= '0;
        end else if (i_cmd.load) begin
            // cursor moves on at accept, squares use the held base
            r_cursor_x <= n_base_x + advance;
            r_line_y   <= n_line_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_cmd.load) begin
            r_bits <= glyph_bits(glyph_select(i_char_code));
        end else if (i_cmd.step) begin
            r_bits <= r_bits >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base_x <= n_base_x;
            r_row    <= '0;
            r_xoff   <= '0;
            r_yoff   <= '0;
        end else if (i_cmd.step) begin
            if (r_row == ROW_W'(GLYPH_ROWS - 1)) begin
                r_row  <= '0;
                r_yoff <= '0;
                r_xoff <= r_xoff + scale_w;
            end else begin
                r_row  <= r_row + 1'b1;
                r_yoff <= r_yoff + scale_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && r_bits[0]) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_bits[0]) begin
            r_rect_x     <= r_base_x + r_xoff;
            r_rect_y     <= r_line_y + r_yoff;
            r_rect_color <= r_fill_color;
            r_last_rect  <= at_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rect_x     = r_rect_x;
    assign o_rect_y     = r_rect_y;
    assign o_rect_color = r_rect_color;
    assign o_last_rect  = r_last_rect;

    a_step_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_out_ready))
        else $error("scan step would overwrite a pending word");

    a_last_is_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && at_last) |-> r_bits[0])
        else $error("final scan position carries no dot");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && at_last && !i_cmd.load) |=> (r_bits == '0))
        else $error("glyph bits left after last square");

endmodule

`default_nettype wire
